FILE: hw/rtl/rgbhsi_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsi_pkg
// Types and constants shared by the RGB to HSI pixel converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbhsi_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] intensity;
  } pixel_out_t;

  localparam int CORDIC_STEPS = 17;
  localparam int CW = 29;
  localparam int AW = 28;

  localparam logic [16:0] SQ3_Q16 = 17'd113512;
  localparam logic signed [AW-1:0] DEG90_Q16 = 28'sd5898240;
  localparam logic [23:0] DEG180_Q16 = 24'd11796480;
  localparam logic [24:0] DEG360_Q16 = 25'd23592960;
  localparam logic [9:0] THIRD_RECIP = 10'd683;
  localparam logic [15:0] DIV360_RECIP = 16'd46603;
  localparam logic [8:0] DEG360 = 9'd360;

  function automatic logic signed [AW-1:0] atan_q16(input logic [4:0] idx);
    logic signed [AW-1:0] v;
    case (idx)
      5'd0:  v = 28'sd2949120;
      5'd1:  v = 28'sd1740967;
      5'd2:  v = 28'sd919879;
      5'd3:  v = 28'sd466945;
      5'd4:  v = 28'sd234379;
      5'd5:  v = 28'sd117304;
      5'd6:  v = 28'sd58666;
      5'd7:  v = 28'sd29335;
      5'd8:  v = 28'sd14668;
      5'd9:  v = 28'sd7334;
      5'd10: v = 28'sd3667;
      5'd11: v = 28'sd1833;
      5'd12: v = 28'sd917;
      5'd13: v = 28'sd458;
      5'd14: v = 28'sd229;
      5'd15: v = 28'sd115;
      5'd16: v = 28'sd57;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Arithmetic right shift that rounds toward zero.
  function automatic logic signed [CW-1:0] shr_tz(input logic signed [CW-1:0] v,
                                                   input int s);
    logic signed [CW-1:0] r;
    if (v[CW-1]) begin
      r = -((-v) >>> s);
    end else begin
      r = v >>> s;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rgb_to_hsi_pixel.sv
// ----------------------------------------------------------------------------
// rgb_to_hsi_pixel
// Converts one 8-bit RGB word to 8-bit hue, saturation and intensity.
// ----------------------------------------------------------------------------
// The block takes one pixel word per cycle and returns its HSI word through
// the A and B setup registers, the 17-stage CORDIC arctangent pipeline and
// the hue scaling stages C, D and E. Saturation uses an 8-step restoring
// divider that runs alongside the first CORDIC stages. When the output is
// stalled, the whole pipeline holds.
`default_nettype none

module rgb_to_hsi_pixel (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire rgbhsi_pkg::pixel_in_t  in_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output rgbhsi_pkg::pixel_out_t      out_data_o
);
  import rgbhsi_pkg::*;

  localparam int N = CORDIC_STEPS;

  logic en;
  assign en = !out_valid_o || !out_stall_i;
  assign in_stall_o = !en;

  // Stage A: sums, minimum and difference terms.
  logic [9:0] sum_a;
  logic [7:0] mn_a;
  logic signed [10:0] x_a;
  logic [7:0] d_a;
  logic [19:0] int_prod_a;

  always_comb begin
    sum_a = {2'b0, in_data_i.red} + {2'b0, in_data_i.green} + {2'b0, in_data_i.blue};
    mn_a = in_data_i.blue;
    if (in_data_i.green < mn_a) begin
      mn_a = in_data_i.green;
    end
    if (in_data_i.red < mn_a) begin
      mn_a = in_data_i.red;
    end
    x_a = $signed({2'b0, in_data_i.red, 1'b0}) - $signed({3'b0, in_data_i.green})
        - $signed({3'b0, in_data_i.blue});
    d_a = (in_data_i.green >= in_data_i.blue) ? in_data_i.green - in_data_i.blue
                                              : in_data_i.blue - in_data_i.green;
    int_prod_a = {10'b0, sum_a} * {10'b0, THIRD_RECIP};
  end

  logic va_q;
  logic [9:0] a_sum_q;
  logic [7:0] a_mn_q;
  logic signed [10:0] a_x_q;
  logic [7:0] a_d_q;
  logic a_grey_q, a_gle_q;
  logic [7:0] a_int_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_sum_q  <= sum_a;
      a_mn_q   <= mn_a;
      a_x_q    <= x_a;
      a_d_q    <= d_a;
      a_grey_q <= (in_data_i.red == in_data_i.green) && (in_data_i.green == in_data_i.blue);
      a_gle_q  <= in_data_i.blue <= in_data_i.green;
      a_int_q  <= int_prod_a[18:11];
    end
  end

  // Stage B: CORDIC vector setup and saturation numerator.
  logic [24:0] y_b;
  logic signed [CW-1:0] xf_b, yf_b;
  logic [9:0] diff_b;
  logic [17:0] num_b;

  always_comb begin
    y_b = 25'(a_d_q) * 25'(SQ3_Q16);
    xf_b = {{2{a_x_q[10]}}, a_x_q, 16'b0};
    yf_b = $signed({4'b0, y_b});
    diff_b = a_sum_q - 10'(3 * a_mn_q);
    num_b = {diff_b, 8'b0} - {8'b0, diff_b};
  end

  logic                 vk_q  [N+1];
  logic signed [CW-1:0] cx_q  [N+1];
  logic signed [CW-1:0] cy_q  [N+1];
  logic signed [AW-1:0] ca_q  [N+1];
  logic [17:0]          rem_q [N+1];
  logic [7:0]           quo_q [N+1];
  logic [9:0]           sum_q [N+1];
  logic                 dz_q  [N+1];
  logic                 xp_q  [N+1];
  logic                 gr_q  [N+1];
  logic                 gl_q  [N+1];
  logic [7:0]           in_q  [N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vk_q[0] <= 1'b0;
    end else if (en) begin
      vk_q[0] <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (a_x_q[10]) begin
        cx_q[0] <= yf_b;
        cy_q[0] <= -xf_b;
        ca_q[0] <= DEG90_Q16;
      end else begin
        cx_q[0] <= xf_b;
        cy_q[0] <= yf_b;
        ca_q[0] <= '0;
      end
      rem_q[0] <= num_b;
      quo_q[0] <= '0;
      sum_q[0] <= a_sum_q;
      dz_q[0]  <= a_d_q == 8'd0;
      xp_q[0]  <= !a_x_q[10] && (a_x_q != 11'sd0);
      gr_q[0]  <= a_grey_q;
      gl_q[0]  <= a_gle_q;
      in_q[0]  <= a_int_q;
    end
  end

  // CORDIC vectoring stages; the first eight also carry one divider step.
  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [CW-1:0] xs, ys;
    logic [17:0] rem_n;
    logic [7:0] quo_n;

    always_comb begin
      xs = shr_tz(cx_q[i], i);
      ys = shr_tz(cy_q[i], i);
    end

    if (i < 8) begin : g_div
      logic [17:0] dv;

      always_comb begin
        dv = {8'b0, sum_q[i]} << (7 - i);
        rem_n = rem_q[i];
        quo_n = quo_q[i];
        if (rem_q[i] >= dv) begin
          rem_n = rem_q[i] - dv;
          quo_n[7-i] = 1'b1;
        end
      end
    end else begin : g_pass
      always_comb begin
        rem_n = rem_q[i];
        quo_n = quo_q[i];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vk_q[i+1] <= 1'b0;
      end else if (en) begin
        vk_q[i+1] <= vk_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        if (!cy_q[i][CW-1]) begin
          cx_q[i+1] <= cx_q[i] + ys;
          cy_q[i+1] <= cy_q[i] - xs;
          ca_q[i+1] <= ca_q[i] + atan_q16(5'(i));
        end else begin
          cx_q[i+1] <= cx_q[i] - ys;
          cy_q[i+1] <= cy_q[i] + xs;
          ca_q[i+1] <= ca_q[i] - atan_q16(5'(i));
        end
        rem_q[i+1] <= rem_n;
        quo_q[i+1] <= quo_n;
        sum_q[i+1] <= sum_q[i];
        dz_q[i+1]  <= dz_q[i];
        xp_q[i+1]  <= xp_q[i];
        gr_q[i+1]  <= gr_q[i];
        gl_q[i+1]  <= gl_q[i];
        in_q[i+1]  <= in_q[i];
      end
    end
  end

  // Stage C: clamp the angle, fold to 0..360 and scale by 255.
  logic [23:0] theta_c;
  logic [24:0] h_c;
  logic [32:0] hp_c;

  always_comb begin
    if (dz_q[N]) begin
      theta_c = xp_q[N] ? 24'd0 : DEG180_Q16;
    end else if (ca_q[N][AW-1]) begin
      theta_c = '0;
    end else if (ca_q[N] > $signed({4'b0, DEG180_Q16})) begin
      theta_c = DEG180_Q16;
    end else begin
      theta_c = ca_q[N][23:0];
    end
    h_c = gl_q[N] ? {1'b0, theta_c} : DEG360_Q16 - {1'b0, theta_c};
    hp_c = {h_c, 8'b0} - {8'b0, h_c};
  end

  logic vc_q;
  logic [16:0] c_t_q;
  logic [7:0] c_sat_q, c_int_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en) begin
      vc_q <= vk_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_t_q   <= gr_q[N] ? 17'd0 : hp_c[32:16];
      c_sat_q <= (sum_q[N] == 10'd0) ? 8'd0 : quo_q[N];
      c_int_q <= in_q[N];
    end
  end

  // Stage D: quotient estimate by 360 through a reciprocal.
  logic [32:0] p_d;
  assign p_d = {16'b0, c_t_q} * {17'b0, DIV360_RECIP};

  logic vd_q;
  logic [16:0] d_t_q;
  logic [8:0] d_q0_q;
  logic [7:0] d_sat_q, d_int_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
    end else if (en) begin
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_t_q   <= c_t_q;
      d_q0_q  <= p_d[32:24];
      d_sat_q <= c_sat_q;
      d_int_q <= c_int_q;
    end
  end

  // Stage E: one correction step, then the output register.
  logic [17:0] rr_e;
  logic [9:0] q_e;
  logic [7:0] hue_e;

  always_comb begin
    rr_e = {1'b0, d_t_q} - 18'({9'b0, d_q0_q} * {9'b0, DEG360});
    q_e = (rr_e >= {9'b0, DEG360}) ? {1'b0, d_q0_q} + 10'd1 : {1'b0, d_q0_q};
    hue_e = (q_e > 10'd255) ? 8'd255 : q_e[7:0];
  end

  logic vo_q;
  pixel_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en) begin
      vo_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.hue        <= hue_e;
      out_q.saturation <= d_sat_q;
      out_q.intensity  <= d_int_q;
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the RGB to HSI pixel converter. A queue of
// pixel words feeds a clocked driver; a clocked monitor compares every output
// word with a predicted HSI word (exact saturation and intensity, CORDIC hue
// computed in the same fixed-point format the design specifies).
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import rgbhsi_pkg::*;

  localparam int LATENCY = 22;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  pixel_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  pixel_out_t out_data_o;

  pixel_in_t pending_pixels[$];
  pixel_out_t expected_hsi[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_count = 0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;
  bit stim_done = 1'b0;

  rgb_to_hsi_pixel dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic longint tz_shift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-v) >>> s);
  endfunction

  function automatic longint arctan_step(int i);
    longint tbl[17] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                        29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57};
    return tbl[i];
  endfunction

  function automatic longint upper_angle(longint x0, longint y0);
    longint x, y, ang, xs, ys, t;
    x = x0;
    y = y0;
    ang = 0;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      ang = 90 * 65536;
    end
    for (int i = 0; i < 17; i++) begin
      xs = tz_shift(x, i);
      ys = tz_shift(y, i);
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        ang += arctan_step(i);
      end else begin
        x = x - ys;
        y = y + xs;
        ang -= arctan_step(i);
      end
    end
    if (ang < 0) ang = 0;
    if (ang > 180 * 65536) ang = 180 * 65536;
    return ang;
  endfunction

  function automatic pixel_out_t convert_pixel(pixel_in_t p);
    pixel_out_t o;
    longint r, g, b, sum, mn, hue, sat, x, d, theta, h;
    r = p.red;
    g = p.green;
    b = p.blue;
    sum = r + g + b;
    mn = b;
    hue = 0;
    sat = 0;
    if (g < mn) mn = g;
    if (r < mn) mn = r;
    if (!(r == g && g == b)) begin
      x = 2 * r - g - b;
      d = (g > b) ? g - b : b - g;
      if (d == 0) theta = (x > 0) ? 0 : 180 * 65536;
      else theta = upper_angle(x * 65536, d * 113512);
      h = (b <= g) ? theta : 360 * 65536 - theta;
      hue = (h * 255) / (360 * 65536);
      if (hue > 255) hue = 255;
      if (hue < 0) hue = 0;
    end
    if (sum != 0) sat = (255 * (sum - 3 * mn)) / sum;
    o.hue = hue[7:0];
    o.saturation = sat[7:0];
    o.intensity = 8'(sum / 3);
    return o;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic add_pixel(int r, int g, int b);
    pixel_in_t p;
    p.red = 8'(r);
    p.green = 8'(g);
    p.blue = 8'(b);
    pending_pixels.push_back(p);
  endtask

  task automatic drain_pipeline();
    while (pending_pixels.size() != 0 || in_valid_i) @(posedge clk_i);
  endtask

  // Driver: offers the next queued word, idling at random.
  always @(posedge clk_i) begin
    if (!in_valid_i || !in_stall_o) begin
      if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_pixels.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall, with one long hold-off counted here.
  always @(posedge clk_i) begin
    if (hold_go && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_count <= hold_count + 1;
      if (hold_count >= HOLD_CYCLES - 1) hold_done <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Monitor: records accepted inputs and checks accepted outputs.
  always @(posedge clk_i) begin
    pixel_out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) expected_hsi.push_back(convert_pixel(in_data_i));
      if (out_valid_o && !out_stall_i) begin
        if (expected_hsi.size() == 0) begin
          report_mismatch("unexpected word", 0, 0);
        end else begin
          want = expected_hsi.pop_front();
          if (out_data_o.hue != want.hue)
            report_mismatch("hue", int'(out_data_o.hue), int'(want.hue));
          if (out_data_o.saturation != want.saturation)
            report_mismatch("saturation", int'(out_data_o.saturation),
                            int'(want.saturation));
          if (out_data_o.intensity != want.intensity)
            report_mismatch("intensity", int'(out_data_o.intensity),
                            int'(want.intensity));
        end
      end
    end
  end

  // Watchdog on cycles with no accepted word.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (rst_ni && !stim_done) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int phase_idle[4] = '{0, 71, 0, 7};
    int phase_stall[4] = '{0, 0, 71, 7};
    int bounded;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_pixel(0, 0, 0);
    add_pixel(255, 255, 255);
    add_pixel(128, 128, 128);
    add_pixel(255, 0, 0);
    add_pixel(0, 255, 0);
    add_pixel(0, 0, 255);
    add_pixel(255, 255, 0);
    add_pixel(0, 255, 255);
    add_pixel(255, 0, 255);
    add_pixel(10, 50, 50);
    add_pixel(200, 50, 50);
    add_pixel(50, 50, 50);
    add_pixel(1, 0, 0);
    add_pixel(0, 1, 0);
    add_pixel(0, 0, 1);
    add_pixel(254, 255, 255);
    add_pixel(170, 85, 0);
    add_pixel(0, 85, 170);
    add_pixel(255, 1, 2);
    drain_pipeline();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = phase_idle[ph];
      recv_stall_pct = phase_stall[ph];
      for (int i = 0; i < 115; i++) begin
        case ($urandom_range(3))
          0: add_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
          1: begin
            bounded = $urandom_range(255);
            add_pixel($urandom_range(255), bounded, bounded);
          end
          2: add_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255) | 8'h80);
          default: add_pixel($urandom_range(1) * 255, $urandom_range(7), $urandom_range(255));
        endcase
      end
      drain_pipeline();
    end

    send_idle_pct = 7;
    recv_stall_pct = 7;
    for (int i = 0; i < 60; i++)
      add_pixel($urandom_range(255), $urandom_range(255), $urandom_range(255));
    @(posedge clk_i);
    hold_go <= 1'b1;
    drain_pipeline();

    stim_done = 1'b1;
    bounded = 0;
    while (expected_hsi.size() != 0 && bounded < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      bounded++;
    end
    repeat (LATENCY + 10) @(posedge clk_i);
    if (errors == 0 && expected_hsi.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
